// ----- rtl/waveform_sample_generator_unit_macros.svh -----
// assertion macros for the waveform sample generator
`ifndef WAVEFORM_SAMPLE_GENERATOR_UNIT_MACROS_SVH
`define WAVEFORM_SAMPLE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define WSG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/wsg_pkg.sv -----
// shared types, constants and sine table for the waveform sample generator
`default_nettype none
package wsg_pkg;
	localparam int unsigned SAMPLE_RATE_HZ = 44100;
	localparam int unsigned MAX_PERIOD     = 4096;
	localparam int unsigned TABLE_DEPTH    = 256;
	localparam int unsigned SINE_ROM_DEPTH = 256;

	localparam int unsigned NUM_W     = 22;
	localparam int unsigned DEN_W     = 16;
	localparam int unsigned DIV_STEPS = NUM_W;

	localparam logic [2:0] MODE_SQUARE = 3'd0;
	localparam logic [2:0] MODE_SAW    = 3'd1;
	localparam logic [2:0] MODE_TRI    = 3'd2;
	localparam logic [2:0] MODE_SINE   = 3'd3;
	localparam logic [2:0] MODE_CUSTOM = 3'd4;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_LEN  = 1'b1;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [7:0] sine_rom_t [0:SINE_ROM_DEPTH];

	typedef struct packed {
		logic        req;
		logic [11:0] k;
		logic [2:0]  mode;
		logic [8:0]  len;
		logic [7:0]  addr;
		logic [7:0]  data;
		logic [15:0] freq;
		logic [12:0] period;
		logic        err;
		logic [7:0]  val;
		logic        use_d3;
		logic        beyond;
		logic [7:0]  pos;
	} wsg_ctx_t;

	// shift-subtract division, only evaluated while the sine table is built
	function automatic longint unsigned udiv_elab(input longint unsigned a,
			input longint unsigned b);
		longint unsigned quo;
		longint unsigned rem;
		quo = 0;
		rem = 0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], a[i]};
			quo = quo << 1;
			if (rem >= b) begin
				rem    = rem - b;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(128*sin(x)), x in q30, taylor series to the 11th power
	function automatic logic [7:0] sine_entry(input longint unsigned x);
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned s;
		term = x;
		pos  = x;
		neg  = 0;
		for (int n = 1; n <= 5; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = udiv_elab(term, longint'((2 * n) * (2 * n + 1)));
			if (n % 2 == 1) begin
				neg += term;
			end else begin
				pos += term;
			end
		end
		s = (pos > neg) ? pos - neg : 0;
		return 8'((s * 128 + Q30_ONE / 2) >> 30);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int q = 0; q <= SINE_ROM_DEPTH; q++) begin
			rom[q] = sine_entry((longint'(q) * HALF_PI_Q30) / SINE_ROM_DEPTH);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();
endpackage
`default_nettype wire

// ----- rtl/wsg_div.sv -----
// pipelined restoring divider, one quotient bit per stage, context travels alongside
`default_nettype none
module wsg_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire logic [wsg_pkg::NUM_W-1:0] num,
	input  wire logic [wsg_pkg::DEN_W-1:0] den,
	input  wire wsg_pkg::wsg_ctx_t         ctx_in,
	output logic                           out_vld,
	output logic [wsg_pkg::NUM_W-1:0]      quo,
	output wsg_pkg::wsg_ctx_t              ctx_out
);
	import wsg_pkg::*;

	logic               vld_s [0:DIV_STEPS];
	logic [NUM_W-1:0]   num_s [0:DIV_STEPS];
	logic [DEN_W-1:0]   den_s [0:DIV_STEPS];
	logic [DEN_W-1:0]   rem_s [0:DIV_STEPS];
	logic [NUM_W-1:0]   quo_s [0:DIV_STEPS];
	wsg_ctx_t           ctx_s [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= num;
			den_s[0] <= den;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			ctx_s[0] <= ctx_in;
		end
	end

	for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[g-1], num_s[g-1][NUM_W-g]};
			diff  = trial - {1'b0, den_s[g-1]};
			ge    = trial >= {1'b0, den_s[g-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[g] <= num_s[g-1];
				den_s[g] <= den_s[g-1];
				rem_s[g] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[g] <= {quo_s[g-1][NUM_W-2:0], ge};
				ctx_s[g] <= ctx_s[g-1];
			end
		end
	end

	assign out_vld = vld_s[DIV_STEPS];
	assign quo     = quo_s[DIV_STEPS];
	assign ctx_out = ctx_s[DIV_STEPS];
endmodule
`default_nettype wire

// ----- rtl/waveform_sample_generator_unit.sv -----
// Waveform sample generator: takes one item per clock while out_ready allows and returns a sample for each read.
// Each item passes through three 23-stage divider pipelines in series (period, phase, custom
// stretch) plus input, table-read and output registers; throughput is one beat per cycle
// when out_ready stays high. Table writes travel the same pipe and update the custom table
// memory at the read stage, so reads and writes keep their order and give no result beat.
`default_nettype none
module waveform_sample_generator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [15:0] frequency,
	input  wire logic [11:0] sample_index,
	input  wire logic [7:0]  table_addr,
	input  wire logic [7:0]  table_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       sample_value,
	output logic [12:0]      period_length,
	output logic             too_long
);
	import wsg_pkg::*;

	`include "waveform_sample_generator_unit_macros.svh"

	logic [2:0] mode_q;
	logic [8:0] len_q;
	logic       adv;

	logic       vld_s0;
	wsg_ctx_t   ctx_d;
	wsg_ctx_t   ctx_s0;
	logic [8:0] len_eff;

	logic             d1_vld, d2_vld, d3_vld;
	logic [NUM_W-1:0] q1, q2, q3;
	wsg_ctx_t         c1, c2, c3;
	wsg_ctx_t         c2_in, c3_in;
	logic [NUM_W-1:0] num2, num3;
	logic [DEN_W-1:0] den2, den3;

	logic [7:0] wave_mem [0:TABLE_DEPTH-1];
	logic [7:0] rd_s1;
	logic       vld_s1;
	wsg_ctx_t   ctx_s1;
	logic [7:0] pos_sel;

	logic [7:0]  val_fin;
	logic        out_valid_q;
	logic [7:0]  sample_q;
	logic [12:0] period_q;
	logic        too_long_q;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SQUARE;
			len_q  <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[2:0];
				CFG_LEN:  len_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_comb begin
		if (len_q == 9'd0) begin
			len_eff = 9'd1;
		end else if (len_q > 9'(TABLE_DEPTH)) begin
			len_eff = 9'(TABLE_DEPTH);
		end else begin
			len_eff = len_q;
		end
	end

	always_comb begin
		ctx_d      = '0;
		ctx_d.req  = req_type;
		ctx_d.k    = sample_index;
		ctx_d.mode = mode_q;
		ctx_d.len  = len_eff;
		ctx_d.addr = table_addr;
		ctx_d.data = table_data;
		ctx_d.freq = frequency;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s0 <= ctx_d;
		end
	end

	// period = rate / frequency
	wsg_div u_div_period (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s0),
		.num     (NUM_W'(SAMPLE_RATE_HZ)),
		.den     (ctx_s0.freq),
		.ctx_in  (ctx_s0),
		.out_vld (d1_vld),
		.quo     (q1),
		.ctx_out (c1)
	);

	// period known: set up the phase division
	always_comb begin
		logic [11:0]      h;
		logic [11:0]      j;
		logic [NUM_W-1:0] kx;
		h     = '0;
		j     = '0;
		kx    = NUM_W'(c1.k);
		c2_in = c1;
		c2_in.err    = (c1.freq == 16'd0) || (q1 > NUM_W'(MAX_PERIOD));
		c2_in.period = q1[12:0];
		c2_in.val    = '0;
		c2_in.use_d3 = 1'b0;
		h    = q1[12:1];
		j    = c1.k - h;
		num2 = kx * NUM_W'(255);
		den2 = DEN_W'(q1[12:0]);
		case (c1.mode)
			MODE_SQUARE: c2_in.val = (c1.k < h) ? 8'd0 : 8'd255;
			MODE_SAW:    num2 = kx * NUM_W'(255);
			MODE_TRI: begin
				if (c1.k < h) begin
					num2 = kx * NUM_W'(510);
				end else begin
					num2 = NUM_W'(j) * NUM_W'(510) + NUM_W'(q1[12:0]) - NUM_W'(1);
				end
			end
			MODE_SINE:   num2 = kx << 10;
			MODE_CUSTOM: begin
				if (q1[12:0] > {4'd0, c1.len}) begin
					c2_in.use_d3 = 1'b1;
					num2 = NUM_W'(q1[12:0]);
					den2 = DEN_W'(c1.len);
				end else begin
					num2 = kx * NUM_W'(c1.len);
				end
			end
			default: ;
		endcase
	end

	wsg_div u_div_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (d1_vld),
		.num     (num2),
		.den     (den2),
		.ctx_in  (c2_in),
		.out_vld (d2_vld),
		.quo     (q2),
		.ctx_out (c2)
	);

	// phase known: shape the sample, set up the custom stretch division
	always_comb begin
		logic [11:0] h;
		logic [1:0]  quad;
		logic [7:0]  r;
		logic [7:0]  mag;
		logic [8:0]  sum;
		logic [NUM_W-1:0] span;
		h    = c2.period[12:1];
		quad = q2[9:8];
		r    = q2[7:0];
		mag  = quad[0] ? SINE_ROM[9'd256 - {1'b0, r}] : SINE_ROM[{1'b0, r}];
		sum  = {1'b0, mag} + 9'd128;
		span = NUM_W'(c2.len) * NUM_W'(q2[12:0]);
		c3_in = c2;
		c3_in.pos    = q2[7:0];
		c3_in.beyond = c2.use_d3 && (NUM_W'(c2.k) >= span);
		case (c2.mode)
			MODE_SAW: c3_in.val = q2[7:0];
			MODE_TRI: begin
				if (c2.k < h) begin
					c3_in.val = q2[7:0];
				end else if ({1'b0, c2.k} < {h, 1'b0}) begin
					c3_in.val = (q2 > NUM_W'(255)) ? 8'd0 : 8'd255 - q2[7:0];
				end else begin
					c3_in.val = 8'd0;
				end
			end
			MODE_SINE: begin
				if (!quad[1]) begin
					c3_in.val = sum[8] ? 8'd255 : sum[7:0];
				end else begin
					c3_in.val = (mag > 8'd128) ? 8'd0 : 8'd128 - mag;
				end
			end
			default: ;
		endcase
		num3 = NUM_W'(c2.k);
		den3 = q2[DEN_W-1:0];
	end

	wsg_div u_div_stretch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (d2_vld),
		.num     (num3),
		.den     (den3),
		.ctx_in  (c3_in),
		.out_vld (d3_vld),
		.quo     (q3),
		.ctx_out (c3)
	);

	assign pos_sel = c3.use_d3 ? q3[7:0] : c3.pos;

	// custom table: writes and reads are done at the same stage, in pipe order
	always_ff @(posedge clk) begin
		if (adv) begin
			if (d3_vld && c3.req) begin
				wave_mem[c3.addr] <= c3.data;
			end
			rd_s1  <= wave_mem[pos_sel];
			ctx_s1 <= c3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= d3_vld;
		end
	end

	always_comb begin
		if (ctx_s1.mode == MODE_CUSTOM) begin
			val_fin = ctx_s1.beyond ? 8'd0 : rd_s1;
		end else begin
			val_fin = ctx_s1.val;
		end
		if (ctx_s1.err || !({1'b0, ctx_s1.k} < ctx_s1.period)) begin
			val_fin = 8'd0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s1 && !ctx_s1.req;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_q   <= val_fin;
			period_q   <= ctx_s1.err ? 13'd0 : ctx_s1.period;
			too_long_q <= ctx_s1.err;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_value  = sample_q;
	assign period_length = period_q;
	assign too_long      = too_long_q;

	`WSG_ASSERT_NOW(a_err_zeroes, out_valid && too_long, (period_length == 13'd0) && (sample_value == 8'd0), "error beat carries nonzero payload")
	`WSG_ASSERT_NOW(a_period_limit, out_valid, period_length <= 13'(MAX_PERIOD), "period beyond limit on output")
	`WSG_ASSERT_NEXT(a_write_silent, adv && vld_s1 && ctx_s1.req, !out_valid, "table write produced a result beat")
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// self-checking testbench for the waveform sample generator unit
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wsg_pkg::*;

	localparam int unsigned PIPE_DEPTH = 72;
	localparam int unsigned SETTLE     = PIPE_DEPTH + 40;
	localparam int unsigned STALL_LIM  = 6000;

	typedef struct packed {
		logic [7:0]  sample;
		logic [12:0] period;
		logic        err;
	} tone_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [8:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [15:0] frequency;
	logic [11:0] sample_index;
	logic [7:0]  table_addr;
	logic [7:0]  table_data;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  sample_value;
	logic [12:0] period_length;
	logic        too_long;

	waveform_sample_generator_unit dut (.*);

	// predictor state
	logic [7:0]  wave_mem [0:TABLE_DEPTH-1];
	logic [2:0]  cur_mode;
	logic [8:0]  cur_len;
	logic [7:0]  quarter_sine [0:SINE_ROM_DEPTH];
	tone_beat_t  pending_samples [$];

	int unsigned n_sent;
	int unsigned n_writes;
	int unsigned n_checked = 0;
	int unsigned n_bad = 0;
	int unsigned idle_cycles = 0;
	bit          hold_req;
	bit          modes_seen [0:7];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// quarter-wave table from a q30 taylor series
	function automatic logic [7:0] taylor_sine(input longint unsigned x);
		longint unsigned term;
		longint unsigned acc_p;
		longint unsigned acc_n;
		longint unsigned s;
		term  = x;
		acc_p = x;
		acc_n = 0;
		for (int n = 1; n <= 5; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc_n += term;
			end else begin
				acc_p += term;
			end
		end
		s = (acc_p > acc_n) ? acc_p - acc_n : 0;
		return 8'((s * 128 + 64'd536870912) >> 30);
	endfunction

	function automatic tone_beat_t predict_tone(input logic [15:0] f, input logic [11:0] k);
		tone_beat_t r;
		longint unsigned p;
		longint unsigned h;
		longint unsigned v;
		longint unsigned idx;
		longint unsigned quad;
		longint unsigned rr;
		longint unsigned mag;
		longint unsigned c;
		longint unsigned len;
		longint unsigned st;
		longint unsigned pos;
		r = '0;
		v = 0;
		if (f == 0 || (SAMPLE_RATE_HZ / f) > MAX_PERIOD) begin
			r.err = 1'b1;
			return r;
		end
		p = SAMPLE_RATE_HZ / f;
		h = p / 2;
		if (k < p) begin
			case (cur_mode)
				MODE_SQUARE: v = (k < h) ? 0 : 255;
				MODE_SAW: v = (k * 255) / p;
				MODE_TRI: begin
					if (k < h) begin
						v = (k * 510) / p;
					end else if (k < 2 * h) begin
						c = ((k - h) * 510 + p - 1) / p;
						v = (c > 255) ? 0 : 255 - c;
					end else begin
						v = 0;
					end
				end
				MODE_SINE: begin
					idx  = (k * 4 * SINE_ROM_DEPTH) / p;
					quad = (idx / SINE_ROM_DEPTH) & 3;
					rr   = idx % SINE_ROM_DEPTH;
					mag  = quad[0] ? quarter_sine[SINE_ROM_DEPTH - rr] : quarter_sine[rr];
					if (quad < 2) begin
						v = (128 + mag > 255) ? 255 : 128 + mag;
					end else begin
						v = (mag > 128) ? 0 : 128 - mag;
					end
				end
				MODE_CUSTOM: begin
					len = cur_len;
					if (len == 0) len = 1;
					if (len > TABLE_DEPTH) len = TABLE_DEPTH;
					if (p > len) begin
						st = p / len;
						pos = (k >= len * st) ? TABLE_DEPTH : k / st;
					end else begin
						pos = (k * len) / p;
					end
					v = (pos >= TABLE_DEPTH) ? 0 : wave_mem[pos];
				end
				default: v = 0;
			endcase
		end
		r.sample = v[7:0];
		r.period = p[12:0];
		return r;
	endfunction

	// send one beat; called just after a rising edge, returns just after the accepting edge
	task automatic send_beat(input logic rq, input logic [15:0] f, input logic [11:0] k,
			input logic [7:0] a, input logic [7:0] d);
		in_valid     <= 1'b1;
		req_type     <= rq;
		frequency    <= f;
		sample_index <= k;
		table_addr   <= a;
		table_data   <= d;
		@(negedge clk);
		while (!in_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		n_sent++;
		if (rq) begin
			wave_mem[a] = d;
			n_writes++;
		end else begin
			pending_samples.push_back(predict_tone(f, k));
			modes_seen[cur_mode] = 1'b1;
		end
	endtask

	task automatic pause_sender(input int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_MODE) cur_mode = val[2:0];
		else cur_len = val;
	endtask

	function automatic logic [15:0] rand_freq();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 10));
			1, 2, 3: return 16'($urandom_range(11, 300));
			4: return 16'($urandom_range(44101, 65535));
			default: return 16'($urandom_range(301, 44100));
		endcase
	endfunction

	function automatic logic [11:0] rand_index(input logic [15:0] f);
		int unsigned p;
		p = (f == 0) ? 4096 : SAMPLE_RATE_HZ / f;
		if (p == 0 || p > 4096 || $urandom_range(0, 7) == 0) return 12'($urandom);
		return 12'($urandom_range(0, p - 1));
	endfunction

	// random bursts; writes mixed in at the given rate (percent)
	task automatic random_stream(input int unsigned count, input int unsigned wr_pct);
		int unsigned burst;
		logic [15:0] f;
		burst = 0;
		repeat (count) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
			end
			burst--;
			f = rand_freq();
			if ($urandom_range(0, 99) < wr_pct)
				send_beat(1'b1, 16'($urandom), 12'($urandom), 8'($urandom), 8'($urandom));
			else
				send_beat(1'b0, f, rand_index(f), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_reset_defaults();
		send_beat(1'b0, 16'd0, 12'd0, 8'h00, 8'h00);
		send_beat(1'b0, 16'd10, 12'd5, 8'hff, 8'hff);
		send_beat(1'b0, 16'd11, 12'd4008, 8'h00, 8'h00);
		send_beat(1'b0, 16'd11, 12'hfff, 8'h00, 8'h00);
		send_beat(1'b0, 16'd44100, 12'd0, 8'h00, 8'h00);
		send_beat(1'b0, 16'd44101, 12'd0, 8'h00, 8'h00);
		send_beat(1'b0, 16'hffff, 12'hfff, 8'h00, 8'h00);
		send_beat(1'b0, 16'd4410, 12'd4, 8'h00, 8'h00);
		send_beat(1'b0, 16'd4410, 12'd5, 8'h00, 8'h00);
		send_beat(1'b0, 16'd4009, 12'd10, 8'h00, 8'h00);
	endtask

	task automatic test_each_mode();
		for (int m = 0; m < 8; m++) begin
			write_reg(CFG_MODE, 9'(m));
			// odd and even periods, last sample, first sample, midpoint
			send_beat(1'b0, 16'd4009, 12'd0, 8'h00, 8'h00);
			send_beat(1'b0, 16'd4009, 12'd5, 8'h00, 8'h00);
			send_beat(1'b0, 16'd4009, 12'd10, 8'h00, 8'h00);
			send_beat(1'b0, 16'd4410, 12'd9, 8'h00, 8'h00);
			send_beat(1'b0, 16'd100, 12'd441, 8'h00, 8'h00);
			random_stream(60, 0);
		end
	endtask

	logic [8:0] pick_len [0:7] = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511, 9'd37};

	task automatic test_custom_table();
		// fill every entry before any custom read
		for (int a = 0; a < TABLE_DEPTH; a++)
			send_beat(1'b1, 16'($urandom), 12'($urandom), 8'(a), 8'($urandom));
		write_reg(CFG_MODE, 9'(MODE_CUSTOM));
		foreach (pick_len[i]) begin
			write_reg(CFG_LEN, pick_len[i]);
			send_beat(1'b0, 16'd11, 12'd4008, 8'h00, 8'h00);
			send_beat(1'b0, 16'd44100, 12'd0, 8'h00, 8'h00);
			random_stream(50, 15);
		end
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 6; i++) begin
			write_reg(CFG_MODE, 9'($urandom_range(0, 7)));
			write_reg(CFG_LEN, 9'($urandom_range(0, 511)));
			random_stream(50, 10);
		end
	endtask

	task automatic test_backpressure();
		write_reg(CFG_MODE, 9'(MODE_SINE));
		hold_req = 1'b1;
		for (int i = 0; i < 200; i++) send_beat(1'b0, rand_freq(), 12'($urandom), 8'h00, 8'h00);
		// sender waits until the pipe has emptied
		wait_drained();
		random_stream(100, 5);
	endtask

	// receiver stall pattern, with a single long hold-off
	initial begin
		int unsigned phase;
		bit          hold_done;
		out_ready = 1'b0;
		phase = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			phase = (phase + 1) % 400;
			if (phase < 120) out_ready <= 1'b1;
			else if (phase < 250) out_ready <= ($urandom_range(0, 3) != 0);
			else out_ready <= ($urandom_range(0, 1) != 0);
		end
	end

	// result check and watchdog
	always @(negedge clk) begin
		tone_beat_t want;
		if (arst_n) begin
			idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) ? 0 : idle_cycles + 1;
			if (idle_cycles > STALL_LIM) begin
				$display("watchdog: no beat for %0d cycles", idle_cycles);
				$display("waveform_sample_generator_unit test failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				n_checked++;
				if (pending_samples.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) $display("unexpected result beat sample=%0d", sample_value);
				end else begin
					want = pending_samples.pop_front();
					if (want.sample !== sample_value || want.period !== period_length
							|| want.err !== too_long) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch: exp val=%0d per=%0d err=%0d got %0d %0d %0d",
								want.sample, want.period, want.err,
								sample_value, period_length, too_long);
					end
				end
			end
		end
	end

	initial begin
		cfg_valid    = 1'b0;
		cfg_index    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		req_type     = 1'b0;
		frequency    = '0;
		sample_index = '0;
		table_addr   = '0;
		table_data   = '0;
		arst_n       = 1'b0;
		hold_req     = 1'b0;
		n_sent = 0; n_writes = 0;
		cur_mode = MODE_SQUARE;
		cur_len  = 9'd256;
		for (int q = 0; q <= SINE_ROM_DEPTH; q++)
			quarter_sine[q] = taylor_sine((longint'(q) * 64'd1686629713) / SINE_ROM_DEPTH);
		foreach (modes_seen[i]) modes_seen[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_custom_table();
		test_each_mode();
		test_random_mix();
		test_backpressure();
		wait_drained();

		$display("covered %0d beats (%0d table writes), %0d results checked, %0d bad",
			n_sent, n_writes, n_checked, n_bad);
		$display("all eight mode codes, custom lengths 0..511, error and short periods, long stall");
		if (n_bad == 0 && pending_samples.size() == 0) begin
			$display("waveform_sample_generator_unit test passed");
		end else begin
			$display("waveform_sample_generator_unit test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
